// ===== hdl/psac_pkg.sv =====
// Package for the pixel swizzle and alpha compositor: format codes, register
// indexes, frame size limits and the unpacked pixel type. No dependencies.
package psac_pkg;

  // Frame size limits and the widths that follow from them
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Register field widths
  localparam int FMT_W   = 4;
  localparam int SIZE_W  = 13;
  localparam int CFG_A_W = 2;
  localparam int CHAN_W  = 8;
  localparam int SRC_W   = 32;
  localparam int PIX_W   = 24;

  // Rounding bias for the divide by 255
  localparam logic [15:0] ROUND_BIAS = 16'd127;
  localparam logic [7:0]  ALPHA_MAX  = 8'd255;

  // Source byte orders; codes 8..15 are invalid
  typedef enum logic [FMT_W-1:0] {
    FMT_BGRA = 4'd0,
    FMT_BGRX = 4'd1,
    FMT_ARGB = 4'd2,
    FMT_XRGB = 4'd3,
    FMT_RGBA = 4'd4,
    FMT_XBGR = 4'd5,
    FMT_ABGR = 4'd6,
    FMT_RGBX = 4'd7
  } pix_fmt_t;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_BLEND_ENABLE = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_idx_t;

  // Unpacked pixel
  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } argb_t;

  // Control settings handed to the datapath
  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic             blend;
  } mix_ctrl_t;

endpackage

// ===== hdl/psac_mix.sv =====
// Pixel datapath: unpack the source by byte order, then copy or blend over
// the background with rounded divide by 255. Depends on psac_pkg.
module psac_mix (
  input  logic [psac_pkg::SRC_W-1:0] src_pixel,
  input  logic [psac_pkg::PIX_W-1:0] bg_pixel,
  input  psac_pkg::mix_ctrl_t        ctrl,
  output logic [psac_pkg::PIX_W-1:0] result_pixel,
  output logic                       format_error
);
  import psac_pkg::*;

  argb_t             fg;
  logic              bad;
  logic [CHAN_W-1:0] mix_b;
  logic [CHAN_W-1:0] mix_g;
  logic [CHAN_W-1:0] mix_r;

  // Exact rounded blend: x/255 == (x + 1 + (x >> 8)) >> 8 for 16-bit x below 65535
  function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] f,
                                                 input logic [CHAN_W-1:0] k,
                                                 input logic [CHAN_W-1:0] a);
    logic [15:0] sum;
    logic [16:0] q;
    sum = 16'(f * a) + 16'(k * (ALPHA_MAX - a)) + ROUND_BIAS;
    q   = {1'b0, sum} + 17'd1 + 17'(sum[15:8]);
    return q[15:8];
  endfunction

  // Unpack the four source bytes
  always_comb begin
    fg  = '{a: ALPHA_MAX, r: '0, g: '0, b: '0};
    bad = 1'b0;
    case (ctrl.fmt)
      FMT_BGRA: fg = '{a: src_pixel[31:24], r: src_pixel[23:16],
                       g: src_pixel[15:8],  b: src_pixel[7:0]};
      FMT_BGRX: fg = '{a: ALPHA_MAX,        r: src_pixel[23:16],
                       g: src_pixel[15:8],  b: src_pixel[7:0]};
      FMT_ARGB: fg = '{a: src_pixel[7:0],   r: src_pixel[15:8],
                       g: src_pixel[23:16], b: src_pixel[31:24]};
      FMT_XRGB: fg = '{a: ALPHA_MAX,        r: src_pixel[15:8],
                       g: src_pixel[23:16], b: src_pixel[31:24]};
      FMT_RGBA: fg = '{a: src_pixel[31:24], r: src_pixel[7:0],
                       g: src_pixel[15:8],  b: src_pixel[23:16]};
      FMT_XBGR: fg = '{a: ALPHA_MAX,        r: src_pixel[31:24],
                       g: src_pixel[23:16], b: src_pixel[15:8]};
      FMT_ABGR: fg = '{a: src_pixel[7:0],   r: src_pixel[31:24],
                       g: src_pixel[23:16], b: src_pixel[15:8]};
      FMT_RGBX: fg = '{a: ALPHA_MAX,        r: src_pixel[7:0],
                       g: src_pixel[15:8],  b: src_pixel[23:16]};
      default:  bad = 1'b1;
    endcase
  end

  // Blend each channel over the background
  assign mix_b = mix_chan(fg.b, bg_pixel[7:0],   fg.a);
  assign mix_g = mix_chan(fg.g, bg_pixel[15:8],  fg.a);
  assign mix_r = mix_chan(fg.r, bg_pixel[23:16], fg.a);

  // Select pass-through, blend or copy
  always_comb begin
    if (bad) begin
      result_pixel = bg_pixel;
    end else if (ctrl.blend) begin
      result_pixel = {mix_r, mix_g, mix_b};
    end else begin
      result_pixel = {fg.r, fg.g, fg.b};
    end
  end

  assign format_error = bad;

endmodule

// ===== hdl/pixel_swizzle_alpha_compositor.sv =====
// Top level of the pixel swizzle and alpha compositor: handshakes, config
// registers, row/frame counters and the two pipeline registers.
// Depends on psac_pkg and psac_mix.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid / in_ready   | source_pixel, background_pixel
//   out     | output    | out_valid / out_ready | result_pixel, format_error,
//           |           |                       | end_of_row, end_of_frame
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per clock while out_ready keeps the output moving: each beat is
// captured in the input register at the accepting edge, passes the unpack and
// blend logic, and is registered in the output register once that one is
// empty or being taken.
// Synchronous active-low reset clears both valid flags and the counters and
// sets the config registers to format 0, blend off and a 1 x 1 frame. A
// stalled output holds; the input register still drains into the output
// register whenever that one is empty or being taken. cfg_ready is always high.
module pixel_swizzle_alpha_compositor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [psac_pkg::SRC_W-1:0]  in_source_pixel,
  input  logic [psac_pkg::PIX_W-1:0]  in_background_pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [psac_pkg::PIX_W-1:0]  out_result_pixel,
  output logic                        out_format_error,
  output logic                        out_end_of_row,
  output logic                        out_end_of_frame,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [psac_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [psac_pkg::SIZE_W-1:0] cfg_data
);
  import psac_pkg::*;

  // Config registers
  logic [FMT_W-1:0]  pixel_format_r;
  logic              blend_enable_r;
  logic [SIZE_W-1:0] frame_width_r;
  logic [SIZE_W-1:0] frame_height_r;

  // Counters
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic             eor, eof;

  // Input stage
  logic              s1_valid_r;
  logic [SRC_W-1:0]  s1_src_r;
  logic [PIX_W-1:0]  s1_bg_r;
  logic              s1_eor_r, s1_eof_r;

  // Output stage
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_err_r, out_eor_r, out_eof_r;

  logic              in_beat, adv;
  mix_ctrl_t         ctrl;
  logic [PIX_W-1:0]  mix_pixel;
  logic              mix_err;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign in_beat   = in_valid && in_ready;

  // Write config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= '0;
      blend_enable_r <= 1'b0;
      frame_width_r  <= SIZE_W'(1);
      frame_height_r <= SIZE_W'(1);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PIXEL_FORMAT: pixel_format_r <= cfg_data[FMT_W-1:0];
        CFG_BLEND_ENABLE: blend_enable_r <= cfg_data[0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Clamp the frame size to its last column and row
  always_comb begin
    if (frame_width_r == '0) begin
      last_col = '0;
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(frame_width_r - 1'b1);
    end
    if (frame_height_r == '0) begin
      last_row = '0;
    end else if (int'(frame_height_r) > MAX_HEIGHT) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(frame_height_r - 1'b1);
    end
  end

  // Flag row and frame ends and advance the counters
  always_comb begin
    eor         = col_cnt_r >= last_col;
    eof         = eor && (row_cnt_r >= last_row);
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (eor) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = eof ? '0 : row_cnt_r + 1'b1;
    end else begin
      col_cnt_nxt = col_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_beat) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_src_r <= in_source_pixel;
      s1_bg_r  <= in_background_pixel;
      s1_eor_r <= eor;
      s1_eof_r <= eof;
    end
  end

  // Unpack and blend
  assign ctrl = '{fmt: pixel_format_r, blend: blend_enable_r};

  psac_mix u_mix (
    .src_pixel    (s1_src_r),
    .bg_pixel     (s1_bg_r),
    .ctrl         (ctrl),
    .result_pixel (mix_pixel),
    .format_error (mix_err)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= mix_pixel;
      out_err_r   <= mix_err;
      out_eor_r   <= s1_eor_r;
      out_eof_r   <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_pixel = out_pixel_r;
  assign out_format_error = out_err_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

endmodule
